[hdl/address_lease_pool_macros.svh]
// Assertion macros of the address lease pool, used by its controller
`ifndef ADDRESS_LEASE_POOL_MACROS_SVH
`define ADDRESS_LEASE_POOL_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ALP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define ALP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/alp_pkg.sv]
// Shared types and constants of the address lease pool
package alp_pkg;

  localparam int MAX_HOST_BITS  = 8;
  localparam int IDENT_SLOTS    = 256;
  localparam int IDENT_W        = 8;
  localparam int SLOT_DEPTH     = 256;
  localparam int SLOT_W         = 8;
  localparam int COUNT_W        = 9;
  localparam int SCAN_CHUNK     = 16;
  localparam int SCAN_STEPS     = IDENT_SLOTS / SCAN_CHUNK;
  localparam int SCAN_IDX_W     = $clog2(SCAN_STEPS);
  localparam int SCAN_POS_W     = $clog2(SCAN_CHUNK);

  // Slot states
  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_ONLINE  = 2'd1;
  localparam logic [1:0] ST_OFFLINE = 2'd2;

  // Commands
  localparam logic [1:0] CMD_EXISTING = 2'd0;
  localparam logic [1:0] CMD_NEW      = 2'd1;
  localparam logic [1:0] CMD_REASSIGN = 2'd2;
  localparam logic [1:0] CMD_RELEASE  = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_DISABLED = 2'd1;
  localparam logic [1:0] STAT_FAMILY   = 2'd2;
  localparam logic [1:0] STAT_NONE     = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_BASE      = 2'd1;
  localparam logic [1:0] REG_HOST_BITS = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic calc;
    logic scan_step;
    logic link_rd;
    logic pop_wr;
    logic slot_chk;
    logic clr_wr;
    logic finish;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic       enabled;
    logic       fam_ok;
    logic [1:0] cmd;
    logic       id_nonempty;
    logic       offline_zero;
    logic       scan_hit;
    logic       scan_last;
    logic       clr_last;
  } dp_stat_t;

endpackage

[hdl/alp_ram.sv]
// Generic single-write, single-read RAM with registered read data
module alp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/alp_ctrl.sv]
// Controller state machine of the address lease pool
`include "address_lease_pool_macros.svh"

module alp_ctrl import alp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CLEAR    = 4'd1;
  localparam logic [3:0] S_DECODE   = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_FIFO_RD  = 4'd4;
  localparam logic [3:0] S_LINK_RD  = 4'd5;
  localparam logic [3:0] S_POP_WR   = 4'd6;
  localparam logic [3:0] S_SLOT_RD  = 4'd7;
  localparam logic [3:0] S_SLOT_CHK = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_DECODE: begin
        cmd.calc = 1'b1;
        if (!stat.enabled || !stat.fam_ok) begin
          state_next = S_DONE;
        end else begin
          unique case (stat.cmd)
            CMD_EXISTING: state_next = stat.id_nonempty ? S_FIFO_RD : S_SLOT_RD;
            CMD_REASSIGN: state_next = stat.offline_zero ? S_DONE : S_SCAN;
            default:      state_next = S_SLOT_RD;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit) state_next = S_FIFO_RD;
        else if (stat.scan_last) state_next = S_DONE;
      end
      S_FIFO_RD: state_next = S_LINK_RD;
      S_LINK_RD: begin
        cmd.link_rd = 1'b1;
        state_next = S_POP_WR;
      end
      S_POP_WR: begin
        cmd.pop_wr = 1'b1;
        state_next = S_DONE;
      end
      S_SLOT_RD: state_next = S_SLOT_CHK;
      S_SLOT_CHK: begin
        cmd.slot_chk = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `ALP_ASSERT_NEXT(a_accept_decode, start && !busy, state == S_DECODE, "accept did not decode")
  `ALP_ASSERT_NEXT(a_scan_pop, state == S_SCAN && stat.scan_hit, state == S_FIFO_RD, "scan hit lost")
  `ALP_ASSERT_NEXT(a_pop_done, state == S_POP_WR, state == S_DONE, "pop did not finish")

endmodule

[hdl/alp_dp.sv]
// Datapath of the address lease pool: registers, lease memories, counters
module alp_dp import alp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  dp_cmd_t       cmd,
  output dp_stat_t      stat,
  input  logic [1:0]    command,
  input  logic [7:0]    identity,
  input  logic [31:0]   address,
  input  logic          family_matches,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output logic          done,
  output logic          granted,
  output logic [31:0]   lease_address,
  output logic [1:0]    status,
  output logic [8:0]    online_count,
  output logic [8:0]    offline_count
);

  // Configuration registers
  logic        pool_enabled;
  logic [31:0] base_address;
  logic [3:0]  host_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_enabled <= 1'b0;
      base_address <= '0;
      host_bits    <= 4'd8;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ENABLE:    pool_enabled <= cfg_data[0];
        REG_BASE:      base_address <= cfg_data;
        REG_HOST_BITS: host_bits    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Item registers
  logic [1:0]          cmd_q;
  logic [IDENT_W-1:0]  id_q;
  logic [31:0]         addr_q;
  logic                fam_q;
  logic [SLOT_W-1:0]   sel;
  logic                sel_ok;
  logic [IDENT_W-1:0]  fq;
  logic [SLOT_W-1:0]   head, tail;
  logic                found;
  logic [SLOT_W-1:0]   found_off;
  logic [SCAN_IDX_W-1:0] scan_idx;
  logic [SLOT_W-1:0]   clr_idx;
  logic [COUNT_W-1:0]  alloc_count, online_total, offline_total;
  logic [IDENT_SLOTS-1:0] nonempty;

  // Memory ports
  logic                slot_we, link_we, fifo_we;
  logic [SLOT_W-1:0]   slot_waddr, link_waddr;
  logic [IDENT_W-1:0]  fifo_waddr;
  logic [9:0]          slot_wdata, slot_rdata;
  logic [SLOT_W-1:0]   link_wdata, link_rdata;
  logic [15:0]         fifo_wdata, fifo_rdata;

  // Pool geometry
  logic [3:0]          eff_bits;
  logic [MAX_HOST_BITS:0] pow, pool_size;
  logic                skip;
  logic [COUNT_W:0]    alloc_sum;
  logic                new_ok;
  logic [COUNT_W-1:0]  new_slot;
  logic [31:0]         diff;
  logic                off_ok;

  always_comb begin
    eff_bits  = (host_bits > 4'(MAX_HOST_BITS)) ? 4'(MAX_HOST_BITS) : host_bits;
    pow       = (MAX_HOST_BITS+1)'(1) << eff_bits;
    skip      = (pow > (MAX_HOST_BITS+1)'(2));
    pool_size = skip ? pow - (MAX_HOST_BITS+1)'(2) : pow;
    alloc_sum = {1'b0, alloc_count} + (COUNT_W+1)'(skip);
    new_ok    = alloc_sum < (COUNT_W+1)'(pool_size);
    new_slot  = alloc_count + COUNT_W'(1) + COUNT_W'(skip);
    diff      = addr_q - base_address;
    off_ok    = (addr_q >= base_address) && (diff <= 32'(pool_size))
                && (diff < 32'(SLOT_DEPTH - 1));
  end

  // Scan window over the nonempty flags
  logic [SCAN_CHUNK-1:0] chunk;
  logic [SCAN_POS_W-1:0] hit_pos;

  always_comb begin
    chunk = nonempty[{scan_idx, SCAN_POS_W'(0)} +: SCAN_CHUNK];
    hit_pos = '0;
    for (int k = SCAN_CHUNK - 1; k >= 0; k--) begin
      if (chunk[k]) hit_pos = SCAN_POS_W'(k);
    end
  end

  // Slot check decision
  logic [1:0]        slot_st;
  logic [IDENT_W-1:0] slot_own;
  logic              chk_hit;

  always_comb begin
    slot_st  = slot_rdata[9:8];
    slot_own = slot_rdata[7:0];
    if (cmd_q == CMD_NEW) begin
      chk_hit = sel_ok && (slot_st == ST_FREE);
    end else begin
      chk_hit = sel_ok && (slot_st == ST_ONLINE) && (slot_own == id_q);
    end
  end

  // Status to controller
  always_comb begin
    stat.enabled      = pool_enabled;
    stat.fam_ok       = fam_q;
    stat.cmd          = cmd_q;
    stat.id_nonempty  = nonempty[id_q];
    stat.offline_zero = (offline_total == '0);
    stat.scan_hit     = |chunk;
    stat.scan_last    = (scan_idx == SCAN_IDX_W'(SCAN_STEPS - 1));
    stat.clr_last     = (clr_idx == SLOT_W'(SLOT_DEPTH - 1));
  end

  // Memory write ports
  always_comb begin
    slot_we = 1'b0; slot_waddr = sel; slot_wdata = {ST_FREE, 8'd0};
    link_we = 1'b0; link_waddr = fifo_rdata[7:0]; link_wdata = sel;
    fifo_we = 1'b0; fifo_waddr = fq; fifo_wdata = {sel, sel};
    if (cmd.clr_wr) begin
      slot_we = 1'b1;
      slot_waddr = clr_idx;
    end
    if (cmd.pop_wr) begin
      slot_we = 1'b1;
      slot_waddr = head;
      slot_wdata = {ST_ONLINE, id_q};
      fifo_we = (head != tail);
      fifo_wdata = {link_rdata, tail};
    end
    if (cmd.slot_chk && chk_hit) begin
      if (cmd_q == CMD_NEW) begin
        slot_we = 1'b1;
        slot_wdata = {ST_ONLINE, id_q};
      end else if (cmd_q == CMD_RELEASE) begin
        slot_we = 1'b1;
        slot_wdata = {ST_OFFLINE, slot_own};
        fifo_we = 1'b1;
        if (nonempty[fq]) begin
          link_we = 1'b1;
          fifo_wdata = {fifo_rdata[15:8], sel};
        end
      end
    end
  end

  alp_ram #(.WIDTH(10), .DEPTH(SLOT_DEPTH)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(sel), .rdata(slot_rdata)
  );

  alp_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_DEPTH)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(fifo_rdata[15:8]), .rdata(link_rdata)
  );

  alp_ram #(.WIDTH(16), .DEPTH(IDENT_SLOTS)) u_fifo (
    .clk(clk), .we(fifo_we), .waddr(fifo_waddr), .wdata(fifo_wdata),
    .raddr(fq), .rdata(fifo_rdata)
  );

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q  <= command;
      id_q   <= identity;
      addr_q <= address;
      fam_q  <= family_matches;
      found  <= 1'b0;
    end
    if (cmd.calc) begin
      fq       <= id_q;
      scan_idx <= '0;
      if (cmd_q == CMD_NEW) begin
        sel    <= new_slot[SLOT_W-1:0];
        sel_ok <= new_ok;
      end else begin
        sel    <= diff[SLOT_W-1:0] + SLOT_W'(1);
        sel_ok <= off_ok;
      end
    end
    if (cmd.scan_step) begin
      scan_idx <= scan_idx + SCAN_IDX_W'(1);
      if (|chunk) fq <= {scan_idx, hit_pos};
    end
    if (cmd.link_rd) begin
      head <= fifo_rdata[15:8];
      tail <= fifo_rdata[7:0];
    end
    if (cmd.pop_wr) begin
      found     <= 1'b1;
      found_off <= head;
    end
    if (cmd.slot_chk) begin
      found     <= chk_hit;
      found_off <= sel;
    end
  end

  // Control state: counters, nonempty flags, clear index
  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_count   <= '0;
      online_total  <= '0;
      offline_total <= '0;
      nonempty      <= '0;
      clr_idx       <= '0;
    end else begin
      if (cmd.clr_wr) clr_idx <= clr_idx + SLOT_W'(1);
      if (cmd.pop_wr) begin
        if (head == tail) nonempty[fq] <= 1'b0;
        if (offline_total != '0) offline_total <= offline_total - COUNT_W'(1);
        online_total <= online_total + COUNT_W'(1);
      end
      if (cmd.slot_chk && chk_hit) begin
        if (cmd_q == CMD_NEW) begin
          alloc_count  <= alloc_count + COUNT_W'(1);
          online_total <= online_total + COUNT_W'(1);
        end else if (cmd_q == CMD_RELEASE) begin
          if (online_total != '0) online_total <= online_total - COUNT_W'(1);
          offline_total <= offline_total + COUNT_W'(1);
          nonempty[fq]  <= 1'b1;
        end
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      online_count  <= online_total;
      offline_count <= offline_total;
      granted       <= 1'b0;
      lease_address <= '0;
      if (!pool_enabled) begin
        status <= STAT_DISABLED;
        if (cmd_q != CMD_RELEASE) begin
          granted       <= 1'b1;
          lease_address <= addr_q;
        end
      end else if (!fam_q) begin
        status <= STAT_FAMILY;
      end else if (found) begin
        status        <= STAT_DONE;
        granted       <= 1'b1;
        lease_address <= base_address + {24'd0, found_off} - 32'd1;
      end else begin
        status <= STAT_NONE;
      end
    end
  end

endmodule

[hdl/address_lease_pool.sv]
// Top level of the address lease pool
//
// Leases pool addresses to 8-bit identity tags. An item (command, identity,
// address, family_matches) is taken at a clock edge with start high and
// busy low. Its one result appears on granted, lease_address, status,
// online_count and offline_count for exactly one cycle with done high;
// the receiver cannot stall it and must take it then.
// Configuration registers (enable, base address, host bits) are written
// over cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high.
// Disabled or mismatched items go from decode straight to done; slot
// lookups and new leases read and then check a slot; an offline pop
// reads the FIFO and link memories and writes the slot; reassignment
// scans the identity flags sixteen at a time. The controller handles one
// item at a time; the next item can be accepted in the cycle that done
// is shown. After reset a clearing pass marks every slot free; busy
// is high meanwhile, while configuration writes are taken as usual.
module address_lease_pool import alp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [7:0]  identity,
  input  logic [31:0] address,
  input  logic        family_matches,
  output logic        done,
  output logic        granted,
  output logic [31:0] lease_address,
  output logic [1:0]  status,
  output logic [8:0]  online_count,
  output logic [8:0]  offline_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  alp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  alp_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .command(command), .identity(identity), .address(address),
    .family_matches(family_matches),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done), .granted(granted), .lease_address(lease_address),
    .status(status), .online_count(online_count), .offline_count(offline_count)
  );

endmodule
